// ===== hdl/ascon_pkg.sv =====
package ascon_pkg;

    localparam int KEY_W        = 64;
    localparam int CFG_IDX_W    = 1;
    localparam int INIT_ROUNDS  = 12;
    localparam int BLOCK_ROUNDS = 6;
    localparam int ROUND_W      = 4;
    localparam logic [63:0] ASCON_IV = 64'h80400c0600000000;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_AD    = 2'd1;
    localparam logic [1:0] OP_MSG   = 2'd2;

    localparam logic [1:0] ST_CIPHER = 2'd0;
    localparam logic [1:0] ST_TAG    = 2'd1;
    localparam logic [1:0] ST_SEQERR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'd1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_READY,
        PH_AD_OPEN,
        PH_MSG
    } phase_t;

    // work kinds handed from front to back
    typedef enum logic [2:0] {
        CMD_START,
        CMD_AD_EMPTY,
        CMD_AD,
        CMD_MSG,
        CMD_SEQERR
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_FINAL
    } back_state_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] nonce_high;
        logic [63:0] nonce_low;
        logic [63:0] block;
        logic [3:0]  byte_count;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] cipher_block;
        logic [3:0]  cipher_count;
        logic [63:0] tag_high;
        logic [63:0] tag_low;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        dsep;
        logic        last;
        logic [63:0] nonce_high;
        logic [63:0] nonce_low;
        logic [63:0] block;
        logic [3:0]  count;
    } cmd_t;

    typedef logic [4:0][63:0] state_t;

    function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
        rotr = (v >> n) | (v << (64 - n));
    endfunction

    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < int'(n)) begin
                m[63-8*i -: 8] = 8'hff;
            end
        end
        byte_mask = m;
    endfunction

    function automatic logic [63:0] pad_block(input logic [63:0] b, input logic [3:0] n);
        logic [63:0] r;
        r = b & byte_mask(n);
        for (int i = 0; i < 8; i++) begin
            if (i == int'(n)) begin
                r[63-8*i -: 8] = 8'h80;
            end
        end
        pad_block = r;
    endfunction

    function automatic state_t ascon_round(input state_t s, input logic [ROUND_W-1:0] i);
        logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
        state_t r;
        x0 = s[0]; x1 = s[1]; x3 = s[3]; x4 = s[4];
        x2 = s[2] ^ {56'd0, 4'hf - i, i};
        x0 ^= x4; x4 ^= x3; x2 ^= x1;
        t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
        x0 ^= t1; x1 ^= t2; x2 ^= t3; x3 ^= t4; x4 ^= t0;
        x1 ^= x0; x0 ^= x4; x3 ^= x2; x2 = ~x2;
        r[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
        r[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
        r[2] = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
        r[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
        r[4] = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
        ascon_round = r;
    endfunction

endpackage

// ===== hdl/ascon_front.sv =====
module ascon_front
    import ascon_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    output logic     cmd_valid,
    input  logic     cmd_stall,
    output cmd_t     cmd
);

    phase_t     phase_reg, phase_next;
    logic       full_reg, full_next;
    cmd_t       cmd_reg, cmd_next;
    logic [3:0] n;
    logic       take;

    assign in_stall  = full_reg;
    assign take      = in_valid && !full_reg;
    assign cmd_valid = full_reg;
    assign cmd       = cmd_reg;
    assign n         = (in_data.byte_count > 4'd8) ? 4'd8 : in_data.byte_count;

    always_comb
    begin
        phase_next = phase_reg;
        full_next  = full_reg;
        cmd_next   = cmd_reg;
        if (full_reg && !cmd_stall) begin
            full_next = 1'b0;
        end
        if (take) begin
            full_next           = 1'b1;
            cmd_next.nonce_high = in_data.nonce_high;
            cmd_next.nonce_low  = in_data.nonce_low;
            cmd_next.block      = in_data.block;
            cmd_next.count      = n;
            cmd_next.dsep       = 1'b0;
            cmd_next.last       = (n != 4'd8);
            cmd_next.kind       = CMD_SEQERR;
            if (in_data.op == OP_START) begin
                cmd_next.kind = CMD_START;
                phase_next    = PH_READY;
            end else if (in_data.op == OP_AD &&
                         (phase_reg == PH_READY || phase_reg == PH_AD_OPEN)) begin
                if (phase_reg == PH_READY && n == 4'd0) begin
                    cmd_next.kind = CMD_AD_EMPTY;
                end else begin
                    cmd_next.kind = CMD_AD;
                end
                phase_next = (n == 4'd8) ? PH_AD_OPEN : PH_MSG;
            end else if (in_data.op == OP_MSG &&
                         (phase_reg == PH_READY || phase_reg == PH_MSG)) begin
                cmd_next.kind = CMD_MSG;
                cmd_next.dsep = (phase_reg == PH_READY);
                phase_next    = (n == 4'd8) ? PH_MSG : PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            full_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            full_reg  <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

// ===== hdl/ascon_back.sv =====
module ascon_back
    import ascon_pkg::*;
#(
    parameter int INIT_R  = INIT_ROUNDS,
    parameter int BLOCK_R = BLOCK_ROUNDS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] key_high,
    input  logic [63:0] key_low,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  cmd_t        cmd,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data
);

    back_state_t         st_reg, st_next;
    state_t              s_reg, s_next;
    logic [ROUND_W-1:0]  rnd_reg, rnd_next;
    logic                fin_reg, fin_next;
    logic                ov_reg, ov_next;
    out_item_t           o_reg, o_next;
    logic [63:0]         x0;
    logic                take;

    localparam logic [ROUND_W-1:0] INIT_FIRST  = ROUND_W'(12 - INIT_R);
    localparam logic [ROUND_W-1:0] BLOCK_FIRST = ROUND_W'(12 - BLOCK_R);
    localparam logic [ROUND_W-1:0] LAST_RND    = ROUND_W'(11);

    assign cmd_stall = (st_reg != BK_IDLE) || ov_reg;
    assign take      = cmd_valid && !cmd_stall;
    assign out_valid = ov_reg;
    assign out_data  = o_reg;

    always_comb
    begin
        st_next  = st_reg;
        s_next   = s_reg;
        rnd_next = rnd_reg;
        fin_next = fin_reg;
        ov_next  = ov_reg;
        o_next   = o_reg;
        x0       = s_reg[0] ^ pad_block(cmd.block, cmd.count);
        if (ov_reg && !out_stall) begin
            ov_next = 1'b0;
        end
        unique case (st_reg)
            BK_IDLE:
            begin
                if (take) begin
                    fin_next = 1'b0;
                    unique case (cmd.kind)
                        CMD_START:
                        begin
                            s_next   = {cmd.nonce_low, cmd.nonce_high, key_low, key_high,
                                        ASCON_IV};
                            rnd_next = INIT_FIRST;
                            st_next  = BK_RUN;
                        end
                        CMD_AD_EMPTY:
                        begin
                            s_next[4] = s_reg[4] ^ 64'd1;
                        end
                        CMD_AD:
                        begin
                            s_next[0] = x0;
                            rnd_next  = BLOCK_FIRST;
                            fin_next  = cmd.last;
                            st_next   = BK_RUN;
                        end
                        CMD_MSG:
                        begin
                            s_next[0] = x0;
                            s_next[4] = s_reg[4] ^ {63'd0, cmd.dsep};
                            ov_next   = 1'b1;
                            o_next    = '0;
                            o_next.cipher_block = x0 & byte_mask(cmd.count);
                            o_next.cipher_count = cmd.count;
                            o_next.status       = ST_CIPHER;
                            if (cmd.last) begin
                                ov_next   = 1'b0;
                                s_next[1] = s_reg[1] ^ key_high;
                                s_next[2] = s_reg[2] ^ key_low;
                                rnd_next  = INIT_FIRST;
                                st_next   = BK_FINAL;
                            end else begin
                                rnd_next = BLOCK_FIRST;
                                st_next  = BK_RUN;
                            end
                        end
                        default:
                        begin
                            ov_next       = 1'b1;
                            o_next        = '0;
                            o_next.status = ST_SEQERR;
                        end
                    endcase
                end
            end
            BK_RUN:
            begin
                s_next   = ascon_round(s_reg, rnd_reg);
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == LAST_RND) begin
                    st_next = BK_IDLE;
                    // start finishes with key fold, AD close with domain bit
                    if (fin_reg) begin
                        s_next[4] = s_next[4] ^ 64'd1;
                    end
                end
            end
            BK_FINAL:
            begin
                s_next   = ascon_round(s_reg, rnd_reg);
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == LAST_RND) begin
                    st_next        = BK_IDLE;
                    s_next[3]      = s_next[3] ^ key_high;
                    s_next[4]      = s_next[4] ^ key_low;
                    ov_next        = 1'b1;
                    o_next.status  = ST_TAG;
                    o_next.tag_high = s_next[3];
                    o_next.tag_low  = s_next[4];
                end
            end
            default:
            begin
                st_next = BK_IDLE;
            end
        endcase
    end

    // key fold after init rounds
    logic start_run_reg;
    logic start_run_next;

    always_comb
    begin
        start_run_next = start_run_reg;
        if (st_reg == BK_IDLE && take) begin
            start_run_next = (cmd.kind == CMD_START);
        end
    end

    state_t s_fold;
    always_comb
    begin
        s_fold = s_next;
        if (st_reg == BK_RUN && rnd_reg == LAST_RND && start_run_reg) begin
            s_fold[3] = s_next[3] ^ key_high;
            s_fold[4] = s_next[4] ^ key_low;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg        <= BK_IDLE;
            ov_reg        <= 1'b0;
            s_reg         <= '0;
            fin_reg       <= 1'b0;
            start_run_reg <= 1'b0;
        end else begin
            st_reg        <= st_next;
            ov_reg        <= ov_next;
            s_reg         <= s_fold;
            fin_reg       <= fin_next;
            start_run_reg <= start_run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg <= rnd_next;
        o_reg   <= o_next;
    end

endmodule

// ===== hdl/ascon_aead_encrypt_core.sv =====
// Ascon-128 AEAD encryption core.
// Input request channel (in_valid / in_stall / in_data): op selects start
// (nonce), associated-data block or message block; byte_count below 8 marks
// the final padded block of its kind. Out of order requests give status 2.
// Output channel (out_valid / out_stall / out_data): one result per message
// block (status 0) or final block with tag (status 1) or sequence error.
// Key is written through cfg_we / cfg_index / cfg_wdata; the user must
// write it only while idle, as the core does not enforce this. A front
// stage classifies requests and holds one in a queue slot; the back stage
// runs one permutation round per cycle. Start runs INIT_R rounds, a full
// AD or message block BLOCK_R, the final message block INIT_R before its
// tag result; an empty AD close runs none; blocks never overlap.
// Reset clears state words, phase and all handshake state.
// A stalled result holds in the output register and blocks new commands.
module ascon_aead_encrypt_core
    import ascon_pkg::*;
#(
    parameter int INIT_R  = INIT_ROUNDS,
    parameter int BLOCK_R = BLOCK_ROUNDS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data
);

    logic [63:0] key_high_reg, key_low_reg;
    logic        cmd_valid, cmd_stall;
    cmd_t        cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_wdata;
                REG_KEY_LOW:  key_low_reg  <= cfg_wdata;
                default:      key_low_reg  <= key_low_reg;
            endcase
        end
    end

    ascon_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd)
    );

    ascon_back #(
        .INIT_R  (INIT_R),
        .BLOCK_R (BLOCK_R)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_high  (key_high_reg),
        .key_low   (key_low_reg),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
